FILE: hw/rtl/bc_pkg.sv
// Package: widths, limits, shared types and the saturating add of the Bray-Curtis block.
package bc_pkg;

    localparam int VALUE_BITS = 24;
    localparam int MAX_LENGTH = 4096;
    localparam int FRAC_BITS  = 16;

    localparam int SUM_BITS   = VALUE_BITS + $clog2(MAX_LENGTH);
    localparam int QUO_BITS   = FRAC_BITS + 1;
    localparam int CNT_BITS   = $clog2(FRAC_BITS + 1);
    localparam int QDEPTH     = 2;
    localparam int QPTR_BITS  = $clog2(QDEPTH);
    localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

    localparam longint unsigned SUM_LIMIT_L =
        ((64'd1 << VALUE_BITS) - 64'd1) * 64'(MAX_LENGTH);
    localparam logic [SUM_BITS-1:0] SUM_LIMIT = SUM_BITS'(SUM_LIMIT_L);

    typedef struct packed {
        logic [SUM_BITS-1:0] sum_first;
        logic [SUM_BITS-1:0] sum_second;
        logic [SUM_BITS-1:0] sum_minimum;
    } sums_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PREP = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_OUT  = 4'b1000
    } back_state_t;

    // add with clamp at the per-sum ceiling
    function automatic logic [SUM_BITS-1:0] sat_add(
        input logic [SUM_BITS-1:0]   acc,
        input logic [VALUE_BITS-1:0] v
    );
        logic [SUM_BITS:0] s;
        begin
            s = {1'b0, acc} + (SUM_BITS + 1)'(v);
            sat_add = (s > {1'b0, SUM_LIMIT}) ? SUM_LIMIT : s[SUM_BITS-1:0];
        end
    endfunction

endpackage

FILE: hw/rtl/bc_in_if.sv
// Interface: input channel carrying one element pair per beat.
interface bc_in_if;
    logic                          valid;
    logic                          ready;
    logic [bc_pkg::VALUE_BITS-1:0] first_value;
    logic [bc_pkg::VALUE_BITS-1:0] second_value;
    logic                          last_element;

    modport source (output valid, first_value, second_value, last_element, input ready);
    modport sink   (input valid, first_value, second_value, last_element, output ready);
endinterface

FILE: hw/rtl/bc_out_if.sv
// Interface: output channel carrying one dissimilarity result per beat.
interface bc_out_if;
    logic                        valid;
    logic                        ready;
    logic [bc_pkg::QUO_BITS-1:0] dissimilarity;
    logic                        undefined;

    modport source (output valid, dissimilarity, undefined, input ready);
    modport sink   (input valid, dissimilarity, undefined, output ready);
endinterface

FILE: hw/rtl/bc_front.sv
// Front end: accumulates the three running sums and hands finished vectors on.
module bc_front (
    input  logic            clk,
    input  logic            rst_n,
    bc_in_if.sink           sample,
    input  bc_pkg::q_stat_t q_stat,
    output logic            push,
    output bc_pkg::sums_t   push_sums
);

    bc_pkg::sums_t sums_reg;
    bc_pkg::sums_t sums_next;
    bc_pkg::sums_t sums_add;
    logic [bc_pkg::VALUE_BITS-1:0] min_val;
    logic accept;

    assign sample.ready = !q_stat.full;
    assign accept       = sample.valid && sample.ready;
    assign min_val      = (sample.first_value < sample.second_value) ?
                          sample.first_value : sample.second_value;

    always_comb
    begin
        sums_add.sum_first   = bc_pkg::sat_add(sums_reg.sum_first,   sample.first_value);
        sums_add.sum_second  = bc_pkg::sat_add(sums_reg.sum_second,  sample.second_value);
        sums_add.sum_minimum = bc_pkg::sat_add(sums_reg.sum_minimum, min_val);
        sums_next = sums_reg;
        if (accept)
        begin
            // clear after the last pair of a vector
            sums_next = sample.last_element ? '0 : sums_add;
        end
    end

    assign push      = accept && sample.last_element;
    assign push_sums = sums_add;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sums_reg <= '0;
        end
        else
        begin
            sums_reg <= sums_next;
        end
    end

endmodule

FILE: hw/rtl/bc_queue.sv
// Queue: two-entry buffer of finished sums between front and back.
module bc_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  bc_pkg::sums_t   push_sums,
    input  logic            pop,
    output bc_pkg::sums_t   head,
    output bc_pkg::q_stat_t q_stat
);

    bc_pkg::sums_t                mem_reg [bc_pkg::QDEPTH];
    logic [bc_pkg::QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [bc_pkg::QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [bc_pkg::QCNT_BITS-1:0] count_reg, count_next;

    assign q_stat.full  = (count_reg == bc_pkg::QCNT_BITS'(bc_pkg::QDEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign head         = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_sums;
        end
    end

endmodule

FILE: hw/rtl/bc_back.sv
// Back end: forms numerator and denominator, runs the restoring divider, holds the result.
module bc_back (
    input  logic            clk,
    input  logic            rst_n,
    input  bc_pkg::q_stat_t q_stat,
    input  bc_pkg::sums_t   head,
    output logic            pop,
    bc_out_if.source        result
);

    bc_pkg::back_state_t state_reg, state_next;

    bc_pkg::sums_t                sums_reg, sums_next;
    logic [bc_pkg::SUM_BITS-1:0]  den_reg, den_next;
    logic [bc_pkg::SUM_BITS:0]    rem_reg, rem_next;
    logic [bc_pkg::QUO_BITS-1:0]  quo_reg, quo_next;
    logic [bc_pkg::CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [bc_pkg::QUO_BITS-1:0]  dis_reg, dis_next;
    logic                         und_reg, und_next;

    logic [bc_pkg::SUM_BITS-1:0]  mn;
    logic [bc_pkg::SUM_BITS:0]    r2;
    logic                         ge;

    // min(B,C) = min(sum1,sum2) - A, and A + min(B,C) = min(sum1,sum2)
    assign mn = (sums_reg.sum_first < sums_reg.sum_second) ?
                sums_reg.sum_first : sums_reg.sum_second;
    assign r2 = (cnt_reg == '0) ? rem_reg : {rem_reg[bc_pkg::SUM_BITS-1:0], 1'b0};
    assign ge = (r2 >= {1'b0, den_reg});

    assign pop                  = (state_reg == bc_pkg::ST_IDLE) && !q_stat.empty;
    assign result.valid         = (state_reg == bc_pkg::ST_OUT);
    assign result.dissimilarity = dis_reg;
    assign result.undefined     = und_reg;

    always_comb
    begin
        state_next = state_reg;
        sums_next  = sums_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        dis_next   = dis_reg;
        und_next   = und_reg;
        case (state_reg)
            bc_pkg::ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    sums_next  = head;
                    state_next = bc_pkg::ST_PREP;
                end
            end
            bc_pkg::ST_PREP:
            begin
                den_next = mn;
                rem_next = {1'b0, mn - sums_reg.sum_minimum};
                quo_next = '0;
                cnt_next = '0;
                if (mn == '0)
                begin
                    dis_next   = '0;
                    und_next   = 1'b1;
                    state_next = bc_pkg::ST_OUT;
                end
                else
                begin
                    state_next = bc_pkg::ST_DIV;
                end
            end
            bc_pkg::ST_DIV:
            begin
                rem_next = ge ? (r2 - {1'b0, den_reg}) : r2;
                quo_next = {quo_reg[bc_pkg::QUO_BITS-2:0], ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == bc_pkg::CNT_BITS'(bc_pkg::FRAC_BITS))
                begin
                    dis_next   = {quo_reg[bc_pkg::QUO_BITS-2:0], ge};
                    und_next   = 1'b0;
                    state_next = bc_pkg::ST_OUT;
                end
            end
            bc_pkg::ST_OUT:
            begin
                if (result.ready)
                begin
                    state_next = bc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bc_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sums_reg <= sums_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dis_reg  <= dis_next;
        und_reg  <= und_next;
    end

endmodule

FILE: hw/rtl/bray_curtis_balanced_component.sv
// Top level: balanced-variation component of the Bray-Curtis dissimilarity.
//
// Usage
//   sample : one element pair per beat (first_value, second_value, last_element).
//            Pairs sum one beat per cycle unless stalled; last_element closes a vector.
//   result : one beat per vector: dissimilarity (unsigned, 1 << 16 means 1.0,
//            truncated) and undefined, set when the denominator is zero, with
//            dissimilarity then zero.
//   Order:   from the beat carrying last_element to result.valid, the queue entry
//            is popped, numerator and denominator are formed, then 17 divider
//            steps run, the last of which loads the result register; with a zero
//            denominator the result register is loaded when they are formed.
//   Throughput: one pair per cycle while the two-entry queue has room. The
//            restoring divider, one quotient bit a cycle, holds the back end
//            until its result is taken; the back end handles one vector at a
//            time, so runs of short vectors may see sample.ready drop.
//   Reset: clears the running sums, the queue and the back end; no result pending.
//   Stall: result stays valid and stable until taken; the back end then holds, the
//          queue fills, and sample.ready falls once both queue entries are in use.
module bray_curtis_balanced_component (
    input  logic       clk,
    input  logic       rst_n,
    bc_in_if.sink      sample,
    bc_out_if.source   result
);

    bc_pkg::q_stat_t q_stat;
    bc_pkg::sums_t   push_sums;
    bc_pkg::sums_t   head;
    logic            push;
    logic            pop;

    // accumulate and close vectors
    bc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample),
        .q_stat    (q_stat),
        .push      (push),
        .push_sums (push_sums)
    );

    // decouple accumulation from division
    bc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_sums (push_sums),
        .pop       (pop),
        .head      (head),
        .q_stat    (q_stat)
    );

    // divide and present the result
    bc_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_stat (q_stat),
        .head   (head),
        .pop    (pop),
        .result (result)
    );

    // a flagged result carries zero
    a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.undefined |-> result.dissimilarity == '0)
        else $error("undefined result with non-zero dissimilarity");

    // fraction never exceeds one
    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.dissimilarity <= (bc_pkg::QUO_BITS'(1) << bc_pkg::FRAC_BITS))
        else $error("dissimilarity above 1.0");

    // queue never both full and empty, and never popped while empty
    a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty) && !(pop && q_stat.empty))
        else $error("queue status inconsistent");

    // input is held off only when the queue is full
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !sample.ready |-> q_stat.full)
        else $error("sample stalled without a full queue");

endmodule

FILE: test/tb_bray_curtis_balanced_component.sv
// Testbench: drives element pairs into the Bray-Curtis balanced-component block and checks each ratio.
module tb_bray_curtis_balanced_component;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [bc_pkg::QUO_BITS-1:0] dissimilarity;
        logic                        undefined;
    } ratio_t;

    // One row of the directed table: the pair is sent count times, and the
    // last-element mark, if set, rides on the final copy only.
    typedef struct packed {
        int                            count;
        logic [bc_pkg::VALUE_BITS-1:0] first;
        logic [bc_pkg::VALUE_BITS-1:0] second;
        logic                          closes;
        logic                          typed;
        ratio_t                        ratio;
    } row_t;

    localparam int                            HALF_PERIOD    = 10;
    localparam int                            RESET_CYCLES   = 12;
    localparam int                            HOLD_CYCLES    = 300;
    localparam int                            SETTLE_CYCLES  = 60;
    localparam int                            WATCHDOG_LIMIT = 5000;
    localparam int                            RANDOM_ITEMS   = 400;
    localparam logic [bc_pkg::VALUE_BITS-1:0] VALUE_MAX      = {bc_pkg::VALUE_BITS{1'b1}};
    localparam logic [bc_pkg::QUO_BITS-1:0]   RATIO_ONE      =
        bc_pkg::QUO_BITS'(1) << bc_pkg::FRAC_BITS;
    localparam logic [bc_pkg::QUO_BITS-1:0]   RATIO_HALF     =
        bc_pkg::QUO_BITS'(1) << (bc_pkg::FRAC_BITS - 1);
    localparam ratio_t                        RATIO_NONE     = '0;
    localparam ratio_t                        RATIO_UNDEF    =
        '{dissimilarity: '0, undefined: 1'b1};
    localparam ratio_t                        RATIO_ZERO     =
        '{dissimilarity: '0, undefined: 1'b0};
    localparam ratio_t                        RATIO_FULL     =
        '{dissimilarity: RATIO_ONE, undefined: 1'b0};
    localparam ratio_t                        RATIO_MID      =
        '{dissimilarity: RATIO_HALF, undefined: 1'b0};
    localparam int                            STIM_ROWS      = 18;

    // Directed stimulus. Rows with typed set carry a ratio that follows from
    // the pairs at sight; the rest are left to the predictor.
    row_t stim_rows [STIM_ROWS] = '{
        // both vectors empty of abundance
        '{1, 24'd0, 24'd0, 1'b1, 1'b1, RATIO_UNDEF},
        // one vector all zero, the other not
        '{1, 24'd0, 24'd5, 1'b1, 1'b1, RATIO_UNDEF},
        '{1, VALUE_MAX, 24'd0, 1'b1, 1'b1, RATIO_UNDEF},
        // identical single-element vectors
        '{1, 24'd7, 24'd7, 1'b1, 1'b1, RATIO_ZERO},
        '{1, VALUE_MAX, VALUE_MAX, 1'b1, 1'b1, RATIO_ZERO},
        // disjoint vectors give exactly one
        '{1, 24'd10, 24'd0, 1'b0, 1'b0, RATIO_NONE},
        '{1, 24'd0, 24'd10, 1'b1, 1'b1, RATIO_FULL},
        '{1, VALUE_MAX, 24'd0, 1'b0, 1'b0, RATIO_NONE},
        '{1, 24'd0, VALUE_MAX, 1'b1, 1'b1, RATIO_FULL},
        // half overlap
        '{1, 24'd3, 24'd1, 1'b0, 1'b0, RATIO_NONE},
        '{1, 24'd1, 24'd3, 1'b1, 1'b1, RATIO_MID},
        // several zero pairs
        '{3, 24'd0, 24'd0, 1'b1, 1'b1, RATIO_UNDEF},
        // alternating bit patterns and assorted values
        '{1, 24'hAAAAAA, 24'h555555, 1'b0, 1'b0, RATIO_NONE},
        '{1, 24'h555555, 24'hAAAAAA, 1'b1, 1'b0, RATIO_NONE},
        '{1, 24'd123456, 24'd654321, 1'b0, 1'b0, RATIO_NONE},
        '{1, 24'd999, 24'd5, 1'b0, 1'b0, RATIO_NONE},
        '{1, 24'd42, 24'd4242, 1'b1, 1'b0, RATIO_NONE},
        '{1, 24'hFFFFFE, 24'h000001, 1'b1, 1'b0, RATIO_NONE}
    };

    logic clk;
    logic rst_n;

    bc_in_if  sample_bus ();
    bc_out_if result_bus ();

    bray_curtis_balanced_component dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_bus),
        .result (result_bus)
    );

    // Side notes that travel with each beat so that the monitor knows
    // whether the row carries a typed ratio.
    logic   note_typed;
    ratio_t note_ratio;

    // Running sums of the predictor.
    logic [bc_pkg::SUM_BITS-1:0] running_first;
    logic [bc_pkg::SUM_BITS-1:0] running_second;
    logic [bc_pkg::SUM_BITS-1:0] running_min;

    ratio_t pending_ratios [$];

    int mismatches;
    int quiet_cycles;
    int items_sent;
    bit sender_gaps_on;
    bit receiver_stalls_on;
    bit hold_request;

    initial clk = 1'b0;
    always #(HALF_PERIOD) clk = ~clk;

    // Add one value to a running sum, clamping at the per-sum ceiling.
    function automatic logic [bc_pkg::SUM_BITS-1:0] clamp_add(
        input logic [bc_pkg::SUM_BITS-1:0]   acc,
        input logic [bc_pkg::VALUE_BITS-1:0] v
    );
        logic [bc_pkg::SUM_BITS:0] total;
        begin
            total = {1'b0, acc} + (bc_pkg::SUM_BITS + 1)'(v);
            clamp_add = (total > {1'b0, bc_pkg::SUM_LIMIT}) ?
                        bc_pkg::SUM_LIMIT : total[bc_pkg::SUM_BITS-1:0];
        end
    endfunction

    // Balanced component min(B,C) / (A + min(B,C)), truncated to FRAC_BITS.
    function automatic ratio_t balanced_ratio(
        input logic [bc_pkg::SUM_BITS-1:0] s_first,
        input logic [bc_pkg::SUM_BITS-1:0] s_second,
        input logic [bc_pkg::SUM_BITS-1:0] s_min
    );
        logic [bc_pkg::SUM_BITS-1:0] b_part;
        logic [bc_pkg::SUM_BITS-1:0] c_part;
        logic [bc_pkg::SUM_BITS-1:0] m_part;
        logic [bc_pkg::SUM_BITS:0]   denom;
        logic [63:0]                 quotient;
        ratio_t                      r;
        begin
            b_part = s_first - s_min;
            c_part = s_second - s_min;
            m_part = (b_part < c_part) ? b_part : c_part;
            denom  = {1'b0, s_min} + {1'b0, m_part};
            if (denom == '0)
            begin
                r = RATIO_UNDEF;
            end
            else
            begin
                quotient        = (64'(m_part) << bc_pkg::FRAC_BITS) / 64'(denom);
                r.dissimilarity = quotient[bc_pkg::QUO_BITS-1:0];
                r.undefined     = 1'b0;
            end
            balanced_ratio = r;
        end
    endfunction

    // Fold one accepted pair into the sums; on the last pair queue the ratio
    // (typed one if the row gives it) and clear the sums.
    task automatic absorb_pair(
        input logic [bc_pkg::VALUE_BITS-1:0] x,
        input logic [bc_pkg::VALUE_BITS-1:0] y,
        input logic                          closes,
        input logic                          typed,
        input ratio_t                        typed_ratio
    );
        begin
            running_first  = clamp_add(running_first, x);
            running_second = clamp_add(running_second, y);
            running_min    = clamp_add(running_min, (x < y) ? x : y);
            if (closes)
            begin
                if (typed)
                    pending_ratios.push_back(typed_ratio);
                else
                    pending_ratios.push_back(balanced_ratio(running_first, running_second,
                                                            running_min));
                running_first  = '0;
                running_second = '0;
                running_min    = '0;
            end
        end
    endtask

    // Input monitor: every accepted beat feeds the predictor.
    always @(posedge clk)
    begin
        if (rst_n && sample_bus.valid && sample_bus.ready)
            absorb_pair(sample_bus.first_value, sample_bus.second_value,
                        sample_bus.last_element, note_typed, note_ratio);
    end

    // Output monitor: compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        ratio_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (pending_ratios.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual dissimilarity %0d undefined %0b",
                         $time, result_bus.dissimilarity, result_bus.undefined);
                mismatches++;
            end
            else
            begin
                want = pending_ratios.pop_front();
                if (result_bus.dissimilarity !== want.dissimilarity)
                begin
                    $display("%0t: dissimilarity expected %0d actual %0d",
                             $time, want.dissimilarity, result_bus.dissimilarity);
                    mismatches++;
                end
                if (result_bus.undefined !== want.undefined)
                begin
                    $display("%0t: undefined expected %0b actual %0b",
                             $time, want.undefined, result_bus.undefined);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: end the run if no beat moves on either side for too long.
    always @(posedge clk)
    begin
        if ((sample_bus.valid && sample_bus.ready) || (result_bus.valid && result_bus.ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_bray_curtis_balanced_component NOT OK");
                $finish;
            end
        end
    end

    // Receiver: stall at random, or hold off for a long stretch on request so
    // that the block backs up and drops sample.ready.
    initial
    begin
        result_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                result_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            result_bus.ready <= !(receiver_stalls_on && ($urandom_range(99) < 8));
        end
    end

    // Offer one pair and hold it until the beat is taken. Gaps drop valid only
    // on falling edges where no new beat is driven.
    task automatic send_pair(
        input logic [bc_pkg::VALUE_BITS-1:0] x,
        input logic [bc_pkg::VALUE_BITS-1:0] y,
        input logic                          closes,
        input logic                          typed,
        input ratio_t                        typed_ratio
    );
        begin
            @(negedge clk);
            while (sender_gaps_on && ($urandom_range(99) < 8))
            begin
                sample_bus.valid <= 1'b0;
                @(negedge clk);
            end
            sample_bus.valid        <= 1'b1;
            sample_bus.first_value  <= x;
            sample_bus.second_value <= y;
            sample_bus.last_element <= closes;
            note_typed              <= typed;
            note_ratio              <= typed_ratio;
            @(posedge clk);
            while (!sample_bus.ready) @(posedge clk);
            items_sent++;
        end
    endtask

    // Drop valid after the last taken beat.
    task automatic release_sample;
        begin
            @(negedge clk);
            sample_bus.valid <= 1'b0;
        end
    endtask

    // Pause the sender until every queued ratio has come back.
    task automatic drain_results;
        begin
            release_sample();
            while (pending_ratios.size() != 0) @(posedge clk);
        end
    endtask

    function automatic logic [bc_pkg::VALUE_BITS-1:0] draw_value;
        int pick;
        begin
            pick = $urandom_range(0, 9);
            case (pick)
                0:       draw_value = '0;
                1:       draw_value = VALUE_MAX;
                2, 3, 4: draw_value = bc_pkg::VALUE_BITS'($urandom_range(0, 255));
                default: draw_value = bc_pkg::VALUE_BITS'($urandom());
            endcase
        end
    endfunction

    // One whole vector pair with random length and random content. The shape
    // picks cases the ratio is sensitive to: a side all zero, equal sides,
    // the second side a little above the first.
    task automatic send_vector(input bit short_only);
        int                            len;
        int                            shape;
        int                            pick;
        logic [bc_pkg::VALUE_BITS-1:0] x;
        logic [bc_pkg::VALUE_BITS-1:0] y;
        begin
            pick = $urandom_range(0, 19);
            if (short_only)
                len = $urandom_range(1, 3);
            else if (pick == 0)
                len = $urandom_range(25, 64);
            else if (pick <= 5)
                len = $urandom_range(7, 24);
            else
                len = $urandom_range(1, 6);
            shape = $urandom_range(0, 9);
            for (int k = 0; k < len; k++)
            begin
                x = draw_value();
                y = draw_value();
                case (shape)
                    0: x = '0;
                    1: y = '0;
                    2: y = x;
                    3: y = (x > VALUE_MAX - 24'd255) ? x :
                           x + bc_pkg::VALUE_BITS'($urandom_range(0, 255));
                    default: ;
                endcase
                send_pair(x, y, (k == len - 1), 1'b0, RATIO_NONE);
            end
        end
    endtask

    // Main sequence.
    initial
    begin
        rst_n                   = 1'b0;
        sample_bus.valid        = 1'b0;
        sample_bus.first_value  = '0;
        sample_bus.second_value = '0;
        sample_bus.last_element = 1'b0;
        note_typed              = 1'b0;
        note_ratio              = RATIO_NONE;
        running_first           = '0;
        running_second          = '0;
        running_min             = '0;
        mismatches              = 0;
        quiet_cycles            = 0;
        items_sent              = 0;
        sender_gaps_on          = 1'b1;
        receiver_stalls_on      = 1'b1;
        hold_request            = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Walk the directed table.
        for (int r = 0; r < STIM_ROWS; r++)
        begin
            for (int k = 0; k < stim_rows[r].count; k++)
            begin
                send_pair(stim_rows[r].first, stim_rows[r].second,
                          stim_rows[r].closes && (k == stim_rows[r].count - 1),
                          stim_rows[r].typed, stim_rows[r].ratio);
            end
        end
        drain_results();

        // Random stretch with no idling on either side.
        sender_gaps_on     = 1'b0;
        receiver_stalls_on = 1'b0;
        items_sent         = 0;
        while (items_sent < RANDOM_ITEMS / 4) send_vector(1'b0);

        // Receiver holds off while short vectors keep coming, so the queue
        // fills and the input stalls.
        sender_gaps_on     = 1'b1;
        receiver_stalls_on = 1'b1;
        hold_request       = 1'b1;
        while (items_sent < RANDOM_ITEMS / 4 + 60) send_vector(1'b1);
        drain_results();

        // Remaining random vectors with idling on both sides.
        while (items_sent < RANDOM_ITEMS) send_vector(1'b0);
        drain_results();

        // Let the back end settle in case a stray result turns up.
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("tb_bray_curtis_balanced_component OK");
        else
            $display("tb_bray_curtis_balanced_component NOT OK");
        $finish;
    end

endmodule
